// ===== design/adp_pkg.sv =====
// ----------------------------------------------------------------------------
// adp_pkg: shared types and codes for the data-processing ALU
// Operation codes, beat payload structs and the NZCV flag struct.
// ----------------------------------------------------------------------------
package adp_pkg;

  // Operation codes carried in req_type
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_AND = 3'd2,
    OP_ORR = 3'd3,
    OP_EOR = 3'd4,
    OP_MOV = 3'd5,
    OP_MVN = 3'd6,
    OP_CMP = 3'd7
  } adp_op_e;

  // Instruction word field positions
  localparam int unsigned SBitPos    = 20;
  localparam int unsigned SignBitPos = 31;

  // Kept condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } adp_flags_t;

  // Input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic        use_immediate;
    logic [31:0] instruction;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic [31:0] rs_value;
  } adp_req_t;

  // Output beat
  typedef struct packed {
    logic [31:0] result_value;
    logic [3:0]  dest_index;
    logic        write_enable;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
  } adp_rsp_t;

endpackage

// ===== design/arm_data_processing_alu_top.sv =====
// ----------------------------------------------------------------------------
// arm_data_processing_alu_top: data-processing ALU with barrel shifter
// An accepted input beat is held in the input register; its result beat is
// then captured in the result register, which drives the output beat.
// Throughput: one instruction per cycle; the input stalls only while both the
// input register and the result register hold a beat and out_ready_i is low.
// Reset clears both valid bits and the kept NZCV flags to zero.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_top import adp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  adp_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output adp_rsp_t out_data_o
);

  logic        req_valid_q;
  adp_req_t    req_q;
  logic        rsp_valid_q;
  adp_rsp_t    rsp_q;
  adp_flags_t  flags_q;
  adp_flags_t  flags_d;
  logic        advance;
  logic [31:0] operand;
  logic        shift_carry;
  logic [31:0] result;
  logic        write_enable;

  // Handshake: compute stage moves when the result register is free
  assign advance    = !rsp_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  // Second operand
  adp_shifter u_shifter (
    .use_immediate_i (req_q.use_immediate),
    .instruction_i   (req_q.instruction),
    .rm_value_i      (req_q.rm_value),
    .rs_value_i      (req_q.rs_value),
    .carry_i         (flags_q.c),
    .operand_o       (operand),
    .carry_o         (shift_carry)
  );

  // Operation and flags
  adp_alu u_alu (
    .req_type_i     (req_q.req_type),
    .s_bit_i        (req_q.instruction[SBitPos]),
    .rn_value_i     (req_q.rn_value),
    .operand_i      (operand),
    .shift_carry_i  (shift_carry),
    .flags_i        (flags_q),
    .result_o       (result),
    .write_enable_o (write_enable),
    .flags_o        (flags_d)
  );

  // Kept flags and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= req_valid_q;
      if (req_valid_q) begin
        flags_q <= flags_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance && req_valid_q) begin
      rsp_q.result_value <= result;
      rsp_q.dest_index   <= req_q.instruction[15:12];
      rsp_q.write_enable <= write_enable;
      rsp_q.flag_n       <= flags_d.n;
      rsp_q.flag_z       <= flags_d.z;
      rsp_q.flag_c       <= flags_d.c;
      rsp_q.flag_v       <= flags_d.v;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  // Flags move only when an instruction leaves the compute stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_valid_q && advance) |=> $stable(flags_q))
    else $error("flags changed without an instruction completing");

  // Flags shown on a fresh result match the kept flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && advance) |=> (rsp_valid_q && rsp_q.flag_n == flags_q.n
      && rsp_q.flag_z == flags_q.z && rsp_q.flag_c == flags_q.c
      && rsp_q.flag_v == flags_q.v))
    else $error("result flags differ from kept flags");

  // A held instruction stays put while the result register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !advance) |=> (req_valid_q && $stable(req_q)))
    else $error("stalled instruction lost or changed");

  // Input side never blocks while the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

// ===== design/adp_shifter.sv =====
// ----------------------------------------------------------------------------
// adp_shifter: second-operand barrel shifter
// Builds the shifted operand from a rotated immediate, an immediate-shifted
// Rm or a register-shifted Rm, along with the shifter carry-out.
// ----------------------------------------------------------------------------
module adp_shifter import adp_pkg::*; (
  input  logic        use_immediate_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] rm_value_i,
  input  logic [31:0] rs_value_i,
  input  logic        carry_i,
  output logic [31:0] operand_o,
  output logic        carry_o
);

  localparam logic [1:0] KindLsl = 2'd0;
  localparam logic [1:0] KindLsr = 2'd1;
  localparam logic [1:0] KindAsr = 2'd2;
  localparam logic [1:0] KindRor = 2'd3;

  logic [4:0]  imm_rot;
  logic [63:0] imm_dbl;
  logic [31:0] imm_val;
  logic [1:0]  kind;
  logic [7:0]  amt;
  logic [4:0]  amt_lo;
  logic        amt_big;
  logic        amt_32;
  logic        sign;
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic [32:0] asr_ext;
  logic [63:0] ror_dbl;
  logic [31:0] shf_val;
  logic        shf_c;

  // Rotated 8-bit immediate: rotate right by twice the 4-bit field
  assign imm_rot = {instruction_i[11:8], 1'b0};
  assign imm_dbl = {24'd0, instruction_i[7:0], 24'd0, instruction_i[7:0]} >> imm_rot;
  assign imm_val = imm_dbl[31:0];

  // Shift kind and amount (register amount uses the low byte of Rs)
  assign kind    = instruction_i[6:5];
  assign amt     = instruction_i[4] ? rs_value_i[7:0] : {3'd0, instruction_i[11:7]};
  assign amt_lo  = amt[4:0];
  assign amt_big = |amt[7:5];
  assign amt_32  = (amt == 8'd32);
  assign sign    = rm_value_i[SignBitPos];

  // Shift datapaths with one extra bit to catch the carry-out
  assign lsl_ext = {1'b0, rm_value_i} << amt_lo;
  assign lsr_ext = {rm_value_i, 1'b0} >> amt_lo;
  assign asr_ext = 33'($signed({rm_value_i, 1'b0}) >>> amt_lo);
  assign ror_dbl = {rm_value_i, rm_value_i} >> amt_lo;

  always_comb begin
    shf_val = rm_value_i;
    shf_c   = carry_i;
    if (amt != 8'd0) begin
      case (kind)
        KindLsl: begin
          if (!amt_big) begin
            shf_val = lsl_ext[31:0];
            shf_c   = lsl_ext[32];
          end else begin
            shf_val = '0;
            shf_c   = amt_32 & rm_value_i[0];
          end
        end
        KindLsr: begin
          if (!amt_big) begin
            shf_val = lsr_ext[32:1];
            shf_c   = lsr_ext[0];
          end else begin
            shf_val = '0;
            shf_c   = amt_32 & sign;
          end
        end
        KindAsr: begin
          if (!amt_big) begin
            shf_val = asr_ext[32:1];
            shf_c   = asr_ext[0];
          end else begin
            shf_val = {32{sign}};
            shf_c   = sign;
          end
        end
        KindRor: begin
          // Multiples of 32 leave the value, carry from bit 31
          shf_val = ror_dbl[31:0];
          shf_c   = ror_dbl[31];
        end
        default: begin
          shf_val = rm_value_i;
          shf_c   = carry_i;
        end
      endcase
    end
  end

  // Operand source select
  always_comb begin
    if (use_immediate_i) begin
      operand_o = imm_val;
      carry_o   = (imm_rot != 5'd0) ? imm_val[SignBitPos] : carry_i;
    end else begin
      operand_o = shf_val;
      carry_o   = shf_c;
    end
  end

endmodule

// ===== design/adp_alu.sv =====
// ----------------------------------------------------------------------------
// adp_alu: arithmetic/logic unit and flag update
// Computes the result for one operation and the next NZCV flags.
// ----------------------------------------------------------------------------
module adp_alu import adp_pkg::*; (
  input  logic [2:0]  req_type_i,
  input  logic        s_bit_i,
  input  logic [31:0] rn_value_i,
  input  logic [31:0] operand_i,
  input  logic        shift_carry_i,
  input  adp_flags_t  flags_i,
  output logic [31:0] result_o,
  output logic        write_enable_o,
  output adp_flags_t  flags_o
);

  logic [32:0] sum;
  logic [32:0] diff;
  logic        add_v;
  logic        sub_v;
  logic        arith;
  logic        arith_c;
  logic        arith_v;
  adp_op_e     op;

  assign op = adp_op_e'(req_type_i);

  // Shared add and subtract paths; subtract carry is "no borrow"
  assign sum   = {1'b0, rn_value_i} + {1'b0, operand_i};
  assign diff  = {1'b0, rn_value_i} + {1'b0, ~operand_i} + 33'd1;
  assign add_v = ~(rn_value_i[SignBitPos] ^ operand_i[SignBitPos])
               & (rn_value_i[SignBitPos] ^ sum[SignBitPos]);
  assign sub_v = (rn_value_i[SignBitPos] ^ operand_i[SignBitPos])
               & (rn_value_i[SignBitPos] ^ diff[SignBitPos]);

  // Result select
  always_comb begin
    result_o = operand_i;
    arith    = 1'b0;
    arith_c  = 1'b0;
    arith_v  = 1'b0;
    case (op)
      OP_ADD: begin
        result_o = sum[31:0];
        arith    = 1'b1;
        arith_c  = sum[32];
        arith_v  = add_v;
      end
      OP_SUB, OP_CMP: begin
        result_o = diff[31:0];
        arith    = 1'b1;
        arith_c  = diff[32];
        arith_v  = sub_v;
      end
      OP_AND:  result_o = rn_value_i & operand_i;
      OP_ORR:  result_o = rn_value_i | operand_i;
      OP_EOR:  result_o = rn_value_i ^ operand_i;
      OP_MOV:  result_o = operand_i;
      OP_MVN:  result_o = ~operand_i;
      default: result_o = operand_i;
    endcase
  end

  assign write_enable_o = (op != OP_CMP);

  // Flag update when S is set; logical ops keep V
  always_comb begin
    flags_o = flags_i;
    if (s_bit_i) begin
      flags_o.n = result_o[SignBitPos];
      flags_o.z = (result_o == 32'd0);
      flags_o.c = arith ? arith_c : shift_carry_i;
      flags_o.v = arith ? arith_v : flags_i.v;
    end
  end

endmodule
